// ----- rtl/pcgbr_pkg.sv -----
`timescale 1ns / 1ps

package pcgbr_pkg;

    localparam logic [63:0] PCG_MULT    = 64'd6364136223846793005;
    localparam logic [63:0] STATE_RESET = 64'd6364136223846793006;
    localparam int unsigned XS_SHIFT_A  = 18;
    localparam int unsigned XS_SHIFT_B  = 27;
    localparam int unsigned ROT_SHIFT   = 59;
    localparam int unsigned FRAC_SHIFT  = 8;

    localparam logic [2:0] CMD_RAW    = 3'd0;
    localparam logic [2:0] CMD_URANGE = 3'd1;
    localparam logic [2:0] CMD_SRANGE = 3'd2;
    localparam logic [2:0] CMD_BOOL   = 3'd3;
    localparam logic [2:0] CMD_FRAC   = 3'd4;
    localparam logic [2:0] CMD_RESEED = 3'd5;

    localparam logic REG_SEED   = 1'b0;
    localparam logic REG_STREAM = 1'b1;

    typedef enum logic [2:0] {
        OP_CONST,
        OP_RAW,
        OP_BOUND,
        OP_BOOL,
        OP_FRAC,
        OP_RESEED
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] bound;
        logic [31:0] base;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LL,
        S_MUL_HL,
        S_MUL_LH,
        S_PROD,
        S_CHECK,
        S_REM,
        S_RS_ADD
    } t_fsm;

    // XSH-RR output permutation of the old state.
    function automatic logic [31:0] xsh_rr(input logic [63:0] s);
        logic [63:0] x;
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [63:0] dbl;
        x   = ((s >> XS_SHIFT_A) ^ s) >> XS_SHIFT_B;
        xs  = x[31:0];
        rot = s[63:59];
        dbl = {xs, xs} >> rot;
        return dbl[31:0];
    endfunction

endpackage

// ----- rtl/pcgbr_front.sv -----
`timescale 1ns / 1ps

module pcgbr_front
    import pcgbr_pkg::*;
(
    input  logic        [2:0]  i_cmd,
    input  logic        [31:0] i_upper,
    input  logic signed [31:0] i_lower,
    output t_item              o_item
);

    logic [31:0] w_lo;
    logic [31:0] w_len;

    assign w_lo  = i_lower;
    assign w_len = i_upper - w_lo + 32'd1;

    // Commands that need no draw are resolved here into a constant result.
    always_comb begin
        o_item.op    = OP_CONST;
        o_item.bound = i_upper;
        o_item.base  = '0;
        unique case (i_cmd)
            CMD_RAW:    o_item.op = OP_RAW;
            CMD_URANGE: begin
                if (i_upper != '0) begin
                    o_item.op = OP_BOUND;
                end
            end
            CMD_SRANGE: begin
                o_item.base  = w_lo;
                o_item.bound = w_len;
                if ((i_lower < $signed(i_upper)) && (w_len != '0)) begin
                    o_item.op = OP_BOUND;
                end
            end
            CMD_BOOL:   o_item.op = OP_BOOL;
            CMD_FRAC:   o_item.op = OP_FRAC;
            CMD_RESEED: o_item.op = OP_RESEED;
            default:    o_item.op = OP_CONST;
        endcase
    end

endmodule

// ----- rtl/pcgbr_fifo.sv -----
`timescale 1ns / 1ps

module pcgbr_fifo
    import pcgbr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/pcgbr_rem.sv -----
`timescale 1ns / 1ps

module pcgbr_rem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);

    // Restoring division of (2^32 - d) by d, one quotient bit per cycle.
    logic [31:0] r_rem;
    logic [31:0] r_num;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_trial;
    logic [32:0] w_diff;

    assign w_trial = {r_rem, r_num[31]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign o_done  = r_done;
    assign o_rem   = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= 32'd0 - i_divisor;
        end else if (r_busy) begin
            r_rem <= w_diff[32] ? w_trial[31:0] : w_diff[31:0];
            r_num <= {r_num[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/pcgbr_back.sv -----
`timescale 1ns / 1ps

module pcgbr_back
    import pcgbr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_seed,
    input  logic [62:0] i_stream,
    input  logic        i_q_empty,
    input  t_item       i_q_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_value
);

    t_fsm        r_fsm;
    t_fsm        n_fsm;
    logic [63:0] r_state;
    logic [63:0] r_inc;
    t_op         r_op;
    logic [31:0] r_bound;
    logic [31:0] r_base;
    logic [31:0] r_draw;
    logic [63:0] r_p;
    logic [31:0] r_c;
    logic [63:0] r_prod;
    logic [31:0] r_thr;
    logic        r_thr_ok;
    logic        r_phase;
    logic        r_out_valid;
    logic [31:0] r_out;

    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_mp;
    logic        w_out_free;
    logic        w_finish;
    logic [31:0] w_result;
    logic        w_rem_start;
    logic        w_rem_done;
    logic [31:0] w_rem;
    logic [31:0] w_hi_sum;
    logic [63:0] w_next_state;
    logic        w_low_ok;

    pcgbr_rem u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_rem_start),
        .i_divisor (r_bound),
        .o_done    (w_rem_done),
        .o_rem     (w_rem)
    );

    assign w_mp         = w_ma * w_mb;
    assign w_out_free   = !r_out_valid || i_ready;
    assign w_hi_sum     = r_p[63:32] + r_c + w_mp[31:0];
    assign w_next_state = {w_hi_sum, r_p[31:0]} + r_inc;
    assign w_low_ok     = (r_prod[31:0] >= r_bound) ||
                          (r_thr_ok && (r_prod[31:0] >= r_thr));
    assign o_valid      = r_out_valid;
    assign o_value      = r_out;

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_IDLE: begin
                if (!i_q_empty && w_out_free) begin
                    if (i_q_item.op != OP_CONST) begin
                        n_fsm = S_MUL_LL;
                    end
                end
            end
            S_MUL_LL: n_fsm = S_MUL_HL;
            S_MUL_HL: n_fsm = S_MUL_LH;
            S_MUL_LH: begin
                if (r_op == OP_BOUND) begin
                    n_fsm = S_PROD;
                end else if ((r_op == OP_RESEED) && !r_phase) begin
                    n_fsm = S_RS_ADD;
                end else begin
                    n_fsm = S_IDLE;
                end
            end
            S_PROD:   n_fsm = S_CHECK;
            S_CHECK: begin
                if (w_low_ok) begin
                    n_fsm = S_IDLE;
                end else if (!r_thr_ok) begin
                    n_fsm = S_REM;
                end else begin
                    n_fsm = S_MUL_LL;
                end
            end
            S_REM: begin
                if (w_rem_done) begin
                    n_fsm = S_CHECK;
                end
            end
            S_RS_ADD: n_fsm = S_MUL_LL;
            default:  n_fsm = S_IDLE;
        endcase
    end

    always_comb begin
        w_ma        = r_state[31:0];
        w_mb        = PCG_MULT[31:0];
        o_pop       = 1'b0;
        w_finish    = 1'b0;
        w_result    = '0;
        w_rem_start = 1'b0;
        unique case (r_fsm)
            S_IDLE: begin
                o_pop    = !i_q_empty && w_out_free;
                w_finish = o_pop && (i_q_item.op == OP_CONST);
                w_result = i_q_item.base;
            end
            S_MUL_HL: begin
                w_ma = r_state[63:32];
            end
            S_MUL_LH: begin
                w_mb = PCG_MULT[63:32];
                unique case (r_op)
                    OP_RAW:    begin w_finish = 1'b1; w_result = r_draw; end
                    OP_BOOL:   begin w_finish = 1'b1; w_result = {31'd0, r_draw[31]}; end
                    OP_FRAC:   begin w_finish = 1'b1; w_result = r_draw >> FRAC_SHIFT; end
                    OP_RESEED: begin w_finish = r_phase; w_result = '0; end
                    default:   w_finish = 1'b0;
                endcase
            end
            S_PROD: begin
                w_ma = r_draw;
                w_mb = r_bound;
            end
            S_CHECK: begin
                w_finish    = w_low_ok;
                w_result    = r_base + r_prod[63:32];
                w_rem_start = !w_low_ok && !r_thr_ok;
            end
            default: begin
                w_finish = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_fsm)
            S_IDLE: begin
                r_op     <= i_q_item.op;
                r_bound  <= i_q_item.bound;
                r_base   <= i_q_item.base;
                r_phase  <= 1'b0;
                r_thr_ok <= 1'b0;
            end
            S_MUL_LL: begin
                r_draw <= xsh_rr(r_state);
                r_p    <= w_mp;
            end
            S_MUL_HL: r_c <= w_mp[31:0];
            S_PROD:   r_prod <= w_mp;
            S_REM: begin
                if (w_rem_done) begin
                    r_thr    <= w_rem;
                    r_thr_ok <= 1'b1;
                end
            end
            S_RS_ADD: r_phase <= 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_state     <= STATE_RESET;
            r_inc       <= 64'd1;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_fsm <= n_fsm;
            if ((r_fsm == S_IDLE) && o_pop && (i_q_item.op == OP_RESEED)) begin
                r_state <= '0;
                r_inc   <= {i_stream, 1'b1};
            end else if (r_fsm == S_MUL_LH) begin
                r_state <= w_next_state;
            end else if (r_fsm == S_RS_ADD) begin
                r_state <= r_state + i_seed;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
                r_out       <= w_result;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_inc_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_inc[0])
        else $error("increment lost its low bit");

    a_finish_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |-> (!r_out_valid || i_ready))
        else $error("result written over an untaken result");

    a_thr_after_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_fsm == S_REM) && w_rem_done) |=> (r_thr_ok && (r_fsm == S_CHECK)))
        else $error("threshold not latched after remainder");

endmodule

// ----- rtl/pcg32_bounded_random_unit.sv -----
`timescale 1ns / 1ps

// PCG32 random unit: a 64-bit LCG stepped with an odd increment and read out through XSH-RR,
// with commands for a raw word, an unbiased value in [0,bound) by multiply and reject, a
// signed inclusive range, a bool, a 0.24 fraction and a reseed from the two registers.
// Each item gives exactly one result item. A front stage sorts each item and resolves the
// cases that need no draw; a two-entry queue feeds the back end, which owns the generator.
// The back end shares one 32x32 multiplier, so a generator step takes the three partial
// products of the 64-bit LCG multiply in turn. A constant result is written as its item is
// popped; raw, bool and fraction items finish after one step, a bounded draw adds PROD and
// CHECK, and a reseed steps, adds the seed and steps again. A bounded draw whose product
// lands in the low danger zone first runs the remainder unit for the threshold, once per
// item, and each rejection takes a new step and product. Output goes through a register, so
// the queue keeps filling while a result waits. There is no clearing pass after reset.
module pcg32_bounded_random_unit
    import pcgbr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic        [2:0]  i_cmd,
    input  logic        [31:0] i_upper,
    input  logic signed [31:0] i_lower,
    output logic               o_valid,
    input  logic               i_ready,
    output logic        [31:0] o_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [3:0]  paddr,
    input  logic        [63:0] pwdata,
    output logic        [63:0] prdata,
    output logic               pready
);

    logic [63:0] r_seed;
    logic [62:0] r_stream;
    t_item       w_front_item;
    t_item       w_q_item;
    logic        w_full;
    logic        w_empty;
    logic        w_pop;
    logic        w_push;

    // Registers sit at byte addresses 0 and 8; bit 3 picks the register.
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[3])
            REG_SEED:   prdata = r_seed;
            REG_STREAM: prdata = {1'b0, r_stream};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= '0;
            r_stream <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[3] == REG_SEED) begin
                r_seed <= pwdata;
            end else begin
                r_stream <= pwdata[62:0];
            end
        end
    end

    assign o_ready = !w_full;
    assign w_push  = i_valid && !w_full;

    pcgbr_front u_front (
        .i_cmd   (i_cmd),
        .i_upper (i_upper),
        .i_lower (i_lower),
        .o_item  (w_front_item)
    );

    pcgbr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_q_item)
    );

    pcgbr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed    (r_seed),
        .i_stream  (r_stream),
        .i_q_empty (w_empty),
        .i_q_item  (w_q_item),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_value   (o_value)
    );

endmodule

// ----- sim/pcgbr_checker.sv -----
`timescale 1ns / 1ps

// Watches the command, result and register channels, keeps its own copy of the
// generator and checks every result item in order.
module pcgbr_checker
    import pcgbr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_upper,
    input  logic [31:0] i_lower,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [31:0] o_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    logic [63:0] gen_st;
    logic [63:0] gen_inc;
    logic [63:0] seed_reg;
    logic [62:0] stream_reg;
    logic [31:0] expected_values[$];

    function automatic logic [31:0] next_word();
        logic [63:0] old;
        logic [31:0] xs;
        logic [4:0]  rot;
        old    = gen_st;
        gen_st = old * 64'd6364136223846793005 + gen_inc;
        xs     = 32'(((old >> 18) ^ old) >> 27);
        rot    = old[63:59];
        return (xs >> rot) | (xs << (6'd32 - rot));
    endfunction

    function automatic void reseed_gen();
        logic [31:0] unused;
        gen_st  = '0;
        gen_inc = {stream_reg, 1'b1};
        unused  = next_word();
        gen_st  = gen_st + seed_reg;
        unused  = next_word();
    endfunction

    function automatic logic [31:0] below_bound(input logic [31:0] bound);
        logic [63:0] prod;
        logic [31:0] thr;
        if (bound == 0) begin
            return 0;
        end
        prod = 64'(next_word()) * 64'(bound);
        if (prod[31:0] < bound) begin
            thr = (32'd0 - bound) % bound;
            while (prod[31:0] < thr) begin
                prod = 64'(next_word()) * 64'(bound);
            end
        end
        return prod[63:32];
    endfunction

    function automatic logic [31:0] predict_value(input logic [2:0] cmd,
                                                  input logic [31:0] up,
                                                  input logic [31:0] lo);
        logic [31:0] w;
        case (cmd)
            CMD_RAW: begin
                return next_word();
            end
            CMD_URANGE: begin
                return below_bound(up);
            end
            CMD_SRANGE: begin
                // An empty or inverted span gives the low end without a draw.
                if ($signed(lo) >= $signed(up)) begin
                    return lo;
                end
                return lo + below_bound(up - lo + 32'd1);
            end
            CMD_BOOL: begin
                w = next_word();
                return {31'd0, w[31]};
            end
            CMD_FRAC: begin
                return next_word() >> 8;
            end
            CMD_RESEED: begin
                reseed_gen();
                return 0;
            end
            default: begin
                return 0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %08h expected %08h", $realtime, what, got, want);
        fail_count++;
    endtask

    assign pending = expected_values.size();

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            seed_reg   = '0;
            stream_reg = '0;
            reseed_gen();
            expected_values.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == 4'd0) begin
                    seed_reg = pwdata;
                end else if (paddr == 4'd8) begin
                    stream_reg = pwdata[62:0];
                end
            end
            if (i_valid && o_ready) begin
                expected_values.push_back(predict_value(i_cmd, i_upper, i_lower));
            end
            if (o_valid && i_ready) begin
                if (expected_values.size() == 0) begin
                    report_mismatch("unexpected result value", o_value, 32'd0);
                end else begin
                    want = expected_values.pop_front();
                    checked++;
                    if (o_value !== want) begin
                        report_mismatch("value", o_value, want);
                    end
                end
            end
        end
    end

    initial begin
        fail_count = 0;
        checked    = 0;
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

// Top level of the regression: it drives commands, register writes and the
// result-side ready, while the checker beside the block does all prediction.
module tb_top;
    import pcgbr_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic        [2:0]  i_cmd;
    logic        [31:0] i_upper;
    logic signed [31:0] i_lower;
    logic               o_valid;
    logic               i_ready;
    logic        [31:0] o_value;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic        [3:0]  paddr;
    logic        [63:0] pwdata;
    logic        [63:0] prdata;
    logic               pready;

    int fail_count;
    int pending;
    int checked;
    int items_sent;
    int settings_used;
    int idle_cycles;

    // Sender burst shaping: gaps are switched off in one phase.
    int  burst_left;
    bit  gaps_on;
    // Set by the stimulus to make the receiver stall for a long stretch.
    bit  long_hold_req;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [3:0] ADDR_SEED   = 4'd0;
    localparam logic [3:0] ADDR_STREAM = 4'd8;

    pcg32_bounded_random_unit dut (.*);

    pcgbr_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_cmd     (i_cmd),
        .i_upper   (i_upper),
        .i_lower   (i_lower),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_value   (o_value),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .fail_count(fail_count),
        .pending   (pending),
        .checked   (checked)
    );

    // A 4 ns clock.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The watchdog ends the run if nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", pending);
            $display("pcg32_bounded_random_unit regression: fail");
            $finish;
        end
    end

    // The receiver works in stretches, each with a stall pattern picked at random: always
    // ready, ready half of the time, or mostly stalled. On request it holds off for a
    // long stretch so that the block's internal queue fills and it stops taking
    // commands.
    initial begin
        int mode;
        int cnt;
        i_ready = 1'b0;
        mode = 0;
        cnt  = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                repeat (300) begin
                    i_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            if (cnt == 0) begin
                mode = $urandom_range(0, 2);
                cnt  = 256;
            end
            cnt--;
            case (mode)
                0: i_ready <= 1'b1;
                1: i_ready <= $urandom_range(0, 1);
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge i_clk);
        end
    end

    // One register write: a setup cycle, then an access cycle. The register
    // takes the data at the edge that closes the access cycle.
    task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Called at a rising edge. Valid is raised and held until the item is
    // taken; ready is looked at in the middle of the cycle, where it is stable.
    task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] up,
                            input logic [31:0] lo);
        int gap;
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_upper <= up;
        i_lower <= lo;
        forever begin
            @(negedge i_clk);
            if (o_ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Waits until every result has come back, then a short settle time.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_generator(input logic [63:0] seed, input logic [62:0] stream);
        write_reg(ADDR_SEED, seed);
        write_reg(ADDR_STREAM, {1'b0, stream});
        settings_used++;
        send_cmd(CMD_RESEED, $urandom, $urandom);
    endtask

    // Random command: mostly generator draws and bounded requests, with
    // bounds picked to exercise both small ranges and the rejection path.
    task automatic send_random_cmd();
        logic [2:0]  cmd;
        logic [31:0] up;
        logic [31:0] lo;
        int pick;
        up   = $urandom;
        lo   = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 14)       cmd = CMD_RAW;
        else if (pick < 44)  cmd = CMD_URANGE;
        else if (pick < 74)  cmd = CMD_SRANGE;
        else if (pick < 84)  cmd = CMD_BOOL;
        else if (pick < 94)  cmd = CMD_FRAC;
        else if (pick < 97)  cmd = CMD_RESEED;
        else                 cmd = 3'($urandom_range(6, 7));
        case ($urandom_range(0, 3))
            0: up = $urandom_range(0, 40);
            1: up = 32'h8000_0000 + $urandom_range(0, 4096);
            default: ;
        endcase
        // Signed spans are often narrow and well ordered.
        if (cmd == CMD_SRANGE && $urandom_range(0, 1) == 1) begin
            up = lo + $urandom_range(0, 1000);
        end
        send_cmd(cmd, up, lo);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_cmd         = CMD_RAW;
        i_upper       = '0;
        i_lower       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_cycles   = 0;
        items_sent    = 0;
        settings_used = 0;
        burst_left    = 0;
        gaps_on       = 1'b1;
        long_hold_req = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items from the reset state.
        send_cmd(CMD_RAW, 32'd0, 32'd0);
        send_cmd(CMD_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_BOOL, 32'd0, 32'd0);
        send_cmd(CMD_FRAC, 32'd0, 32'd0);
        send_cmd(CMD_URANGE, 32'd0, 32'd0);              // zero bound
        send_cmd(CMD_URANGE, 32'd1, 32'd0);
        send_cmd(CMD_URANGE, 32'd2, 32'd0);
        send_cmd(CMD_URANGE, 32'd3, 32'd0);
        send_cmd(CMD_URANGE, 32'hFFFF_FFFF, 32'd0);
        send_cmd(CMD_URANGE, 32'h8000_0001, 32'd0);      // rejects about half the time
        send_cmd(CMD_URANGE, 32'h8000_0001, 32'd0);
        send_cmd(CMD_SRANGE, 32'd5, 32'd5);              // empty span
        send_cmd(CMD_SRANGE, 32'hFFFF_FFFB, 32'd7);      // inverted span
        send_cmd(CMD_SRANGE, 32'h7FFF_FFFF, 32'h8000_0000); // full span wraps
        send_cmd(CMD_SRANGE, 32'd5, 32'hFFFF_FFFB);
        send_cmd(CMD_SRANGE, 32'h8000_0001, 32'h8000_0000);
        send_cmd(CMD_SRANGE, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
        send_cmd(CMD_RESEED, 32'd0, 32'd0);
        send_cmd(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(3'd7, 32'd0, 32'd0);
        send_cmd(CMD_RAW, 32'd0, 32'd0);
        drain();

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_generator(64'd0, 63'd0);
                1: set_generator('1, '1);
                2: set_generator(64'd1, 63'd0);
                3: set_generator({$urandom, $urandom}, 63'({$urandom, $urandom}));
                default: set_generator(64'h8000_0000_0000_0000, 63'd1);
            endcase
            gaps_on = (phase != 1);
            // With the sender running back to back, stall the receiver hard.
            if (phase == 1) long_hold_req = 1'b1;
            for (int n = 0; n < 345; n++) begin
                send_random_cmd();
                // Once mid-run, stop sending until the block has drained.
                if (phase == 3 && n == 170) drain();
            end
            drain();
        end

        $display("Covered %0d command items (%0d results checked) under %0d register settings,",
                 items_sent, checked, settings_used);
        $display("with bursty input, stalled output and a long output hold-off.");
        if (fail_count == 0) begin
            $display("pcg32_bounded_random_unit regression: pass");
        end else begin
            $display("pcg32_bounded_random_unit regression: fail");
        end
        $finish;
    end

endmodule
